// ===== hdl/tsh_pkg.sv =====
// shared types, constants and checksum helpers for the tcp syn header builder
// no dependencies; imported by every module of the block
package tsh_pkg;

    localparam int unsigned HDR_WORDS = 20;
    localparam int unsigned IDX_W     = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    localparam logic [15:0] VER_IHL_TOS_WORD = 16'h4500;
    localparam logic [15:0] TOTAL_LEN        = 16'd40;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [15:0] TCP_LEN          = 16'd20;
    localparam logic [15:0] SYN_CTRL_WORD    = 16'h5002;

    // configuration register indexes
    localparam logic [1:0] REG_SRC_IP       = 2'd0;
    localparam logic [1:0] REG_TIME_TO_LIVE = 2'd1;
    localparam logic [1:0] REG_IP_IDENT     = 2'd2;
    localparam logic [1:0] REG_TCP_WINDOW   = 2'd3;

    localparam logic [31:0] RST_SRC_IP       = 32'd0;
    localparam logic [7:0]  RST_TIME_TO_LIVE = 8'd64;
    localparam logic [15:0] RST_IP_IDENT     = 16'd54321;
    localparam logic [15:0] RST_TCP_WINDOW   = 16'd0;

    localparam int unsigned IP_RAW_W  = 19;
    localparam int unsigned TCP_RAW_W = 20;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [7:0]  time_to_live;
        logic [15:0] ip_ident;
        logic [15:0] tcp_window;
    } cfg_t;

    // one fully resolved header, as it sits in the queue
    typedef struct packed {
        logic [31:0] dst_ip;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] seq_number;
        cfg_t        cfg;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } hdr_t;

    // end-around carry fold and complement
    function automatic logic [15:0] fold_csum(input logic [TCP_RAW_W-1:0] raw);
        logic [16:0] first;
        logic [15:0] second;
        first  = 17'(raw[TCP_RAW_W-1:16]) + 17'(raw[15:0]);
        second = first[15:0] + 16'(first[16]);
        return ~second;
    endfunction

endpackage

// ===== hdl/tsh_front.sv =====
// front end: takes probe requests, snapshots configuration and computes checksums
// depends on tsh_pkg; feeds tsh_queue
module tsh_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [31:0]   dst_ip,
    input  logic [15:0]   dest_port,
    input  logic [15:0]   source_port,
    input  logic [31:0]   seq_number,
    input  tsh_pkg::cfg_t cfg,
    output logic          push,
    output tsh_pkg::hdr_t push_hdr,
    input  logic          q_full
);
    import tsh_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    hdr_t                 s1_hdr_reg;
    logic [IP_RAW_W-1:0]  ip_raw_reg;
    logic [TCP_RAW_W-1:0] tcp_raw_reg;
    logic [IP_RAW_W-1:0]  ip_raw;
    logic [TCP_RAW_W-1:0] tcp_raw;
    logic [TCP_RAW_W-1:0] addr_sum;
    logic                 accept;

    assign push      = s1_valid_reg && !q_full;
    assign req_ready = !s1_valid_reg || !q_full;
    assign accept    = req_valid && req_ready;

    // address words are shared by both sums (pseudo-header)
    always_comb
    begin
        addr_sum = TCP_RAW_W'(cfg.src_ip[31:16]) + TCP_RAW_W'(cfg.src_ip[15:0])
                 + TCP_RAW_W'(dst_ip[31:16]) + TCP_RAW_W'(dst_ip[15:0]);
        ip_raw   = IP_RAW_W'(addr_sum) + IP_RAW_W'(VER_IHL_TOS_WORD) + IP_RAW_W'(TOTAL_LEN)
                 + IP_RAW_W'(cfg.ip_ident) + IP_RAW_W'({cfg.time_to_live, PROTO_TCP});
        tcp_raw  = addr_sum + TCP_RAW_W'(PROTO_TCP) + TCP_RAW_W'(TCP_LEN)
                 + TCP_RAW_W'(source_port) + TCP_RAW_W'(dest_port)
                 + TCP_RAW_W'(seq_number[31:16]) + TCP_RAW_W'(seq_number[15:0])
                 + TCP_RAW_W'(SYN_CTRL_WORD) + TCP_RAW_W'(cfg.tcp_window);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hdr_reg.dst_ip       <= dst_ip;
            s1_hdr_reg.dest_port    <= dest_port;
            s1_hdr_reg.source_port  <= source_port;
            s1_hdr_reg.seq_number   <= seq_number;
            s1_hdr_reg.cfg          <= cfg;
            s1_hdr_reg.ip_csum      <= 16'd0;
            s1_hdr_reg.tcp_csum     <= 16'd0;
            ip_raw_reg              <= ip_raw;
            tcp_raw_reg             <= tcp_raw;
        end
    end

    always_comb
    begin
        push_hdr          = s1_hdr_reg;
        push_hdr.ip_csum  = fold_csum(TCP_RAW_W'(ip_raw_reg));
        push_hdr.tcp_csum = fold_csum(tcp_raw_reg);
    end

endmodule

// ===== hdl/tsh_queue.sv =====
// two-entry queue of resolved headers between front and back end
// depends on tsh_pkg
module tsh_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tsh_pkg::hdr_t push_hdr,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output tsh_pkg::hdr_t head
);
    import tsh_pkg::*;

    hdr_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_hdr;
        end
    end

endmodule

// ===== hdl/tsh_back.sv =====
// back end: walks one header through its twenty words into the output register
// depends on tsh_pkg; pulls from tsh_queue
module tsh_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_not_empty,
    input  tsh_pkg::hdr_t            q_head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              header_word,
    output logic [tsh_pkg::IDX_W-1:0] word_index,
    output logic                     last_word
);
    import tsh_pkg::*;

    hdr_t              cur_reg;
    logic              cur_valid_reg;
    logic              cur_valid_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [15:0]       word_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              last_reg;
    logic              out_load;
    logic              emit;
    logic              at_last;
    logic [15:0]       word_sel;

    assign out_load = !out_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_load;
    assign at_last  = (cnt_reg == LAST_IDX);
    assign pop      = q_not_empty && (!cur_valid_reg || (emit && at_last));

    always_comb
    begin
        unique case (cnt_reg)
            5'd0:    word_sel = VER_IHL_TOS_WORD;
            5'd1:    word_sel = TOTAL_LEN;
            5'd2:    word_sel = cur_reg.cfg.ip_ident;
            5'd3:    word_sel = 16'd0;
            5'd4:    word_sel = {cur_reg.cfg.time_to_live, PROTO_TCP};
            5'd5:    word_sel = cur_reg.ip_csum;
            5'd6:    word_sel = cur_reg.cfg.src_ip[31:16];
            5'd7:    word_sel = cur_reg.cfg.src_ip[15:0];
            5'd8:    word_sel = cur_reg.dst_ip[31:16];
            5'd9:    word_sel = cur_reg.dst_ip[15:0];
            5'd10:   word_sel = cur_reg.source_port;
            5'd11:   word_sel = cur_reg.dest_port;
            5'd12:   word_sel = cur_reg.seq_number[31:16];
            5'd13:   word_sel = cur_reg.seq_number[15:0];
            5'd16:   word_sel = SYN_CTRL_WORD;
            5'd17:   word_sel = cur_reg.cfg.tcp_window;
            5'd18:   word_sel = cur_reg.tcp_csum;
            default: word_sel = 16'd0;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cnt_next       = cnt_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cnt_next       = '0;
        end
        else if (emit && at_last)
        begin
            cur_valid_next = 1'b0;
            cnt_next       = '0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
        end
        if (emit)
        begin
            word_reg  <= word_sel;
            index_reg <= cnt_reg;
            last_reg  <= at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign header_word = word_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

endmodule

// ===== hdl/tcp_syn_header_builder.sv =====
// top level of the tcp syn header builder: config registers, front, queue, back
// depends on tsh_pkg, tsh_front, tsh_queue, tsh_back

// Each probe request on the s_ side becomes a 40-byte IPv4 + TCP SYN header sent
// on the m_ side as twenty 16-bit words, word 0 first, the last one flagged by
// m_tlast. The output port moves one word per cycle while m_tready is high, and
// back-to-back headers leave no gap between them. With nothing ahead of it, a
// request passes through these registers in order: the request and raw sums are
// registered at acceptance, the folded checksums enter the queue, the back end
// takes the header, and the first word is loaded into the output register. Up
// to three requests may be buffered ahead of the header in flight, so the input
// keeps taking requests while output words wait.
// Configuration (source address, TTL, IP ident, TCP window) is captured at
// acceptance; write it only while no request is pending.
module tcp_syn_header_builder
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] dst_ip, [47:32] dest_port, [63:48] source_port, [95:64] seq_number
    input  logic [95:0] s_tdata,
    // header stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] header_word, [20:16] word_index, [23:21] zero
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import tsh_pkg::*;

    cfg_t              cfg_reg;
    logic              cfg_write;
    logic              push;
    hdr_t              push_hdr;
    logic              q_full;
    logic              pop;
    logic              q_not_empty;
    hdr_t              q_head;
    logic [15:0]       header_word;
    logic [IDX_W-1:0]  word_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_ip       <= RST_SRC_IP;
            cfg_reg.time_to_live <= RST_TIME_TO_LIVE;
            cfg_reg.ip_ident     <= RST_IP_IDENT;
            cfg_reg.tcp_window   <= RST_TCP_WINDOW;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SRC_IP:       cfg_reg.src_ip       <= pwdata;
                REG_TIME_TO_LIVE: cfg_reg.time_to_live <= pwdata[7:0];
                REG_IP_IDENT:     cfg_reg.ip_ident     <= pwdata[15:0];
                REG_TCP_WINDOW:   cfg_reg.tcp_window   <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SRC_IP:       prdata = cfg_reg.src_ip;
            REG_TIME_TO_LIVE: prdata = 32'(cfg_reg.time_to_live);
            REG_IP_IDENT:     prdata = 32'(cfg_reg.ip_ident);
            REG_TCP_WINDOW:   prdata = 32'(cfg_reg.tcp_window);
            default:          prdata = 32'd0;
        endcase
    end

    tsh_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .dst_ip       (s_tdata[31:0]),
        .dest_port    (s_tdata[47:32]),
        .source_port  (s_tdata[63:48]),
        .seq_number   (s_tdata[95:64]),
        .cfg          (cfg_reg),
        .push         (push),
        .push_hdr     (push_hdr),
        .q_full       (q_full)
    );

    tsh_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_hdr  (push_hdr),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tsh_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .header_word (header_word),
        .word_index  (word_index),
        .last_word   (m_tlast)
    );

    assign m_tdata = {3'b000, word_index, header_word};

endmodule

// ===== hdl/tsh_checker.sv =====
// port-level checks on the header stream of the tcp syn header builder
// depends on tsh_pkg; bound to tcp_syn_header_builder
module tsh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    import tsh_pkg::*;

    logic [IDX_W-1:0] idx;
    logic [15:0]      word;

    assign idx  = m_tdata[20:16];
    assign word = m_tdata[15:0];

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (idx == LAST_IDX)))
        else $error("tlast does not match final word index");

    // within a header the next word follows at once
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (idx == $past(idx) + IDX_W'(1)))
        else $error("word index did not advance by one");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (idx == '0))
        else $error("new header does not start at word zero");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (idx == '0) |-> (word == VER_IHL_TOS_WORD))
        else $error("first word is not version/ihl/tos");

endmodule

bind tcp_syn_header_builder tsh_checker u_tsh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
